>>> rtl/core/spgb_pkg.sv
`default_nettype none

package spgb_pkg;

   // Widths of the fields on the two channels.
   localparam int ID_W     = 8;
   localparam int POS_W    = 16;
   localparam int STORED_W = 15;
   localparam int Z_W      = 12;
   localparam int TILE_W   = 7;
   localparam int CELL_W   = 2 * TILE_W;

   // Number of grid cells and of distinct entity codes.
   localparam int CELL_COUNT = 1 << CELL_W;
   localparam int ID_SPAN    = 1 << ID_W;

   // Tile limits and the coordinates that out-of-range tiles wrap to.
   localparam logic [7:0]          X_TILE_MAX = 8'h7f;
   localparam logic [7:0]          Y_TILE_MAX = 8'h5f;
   localparam logic [STORED_W-1:0] X_LOW_WRAP = 15'h7e00;
   localparam logic [STORED_W-1:0] Y_LOW_WRAP = 15'h5e00;
   localparam logic [STORED_W-1:0] HIGH_WRAP  = 15'h0200;

   // One entry of the entity memory.
   typedef struct packed {
      logic [ID_W-1:0]   link_next;
      logic [ID_W-1:0]   link_prev;
      logic [CELL_W-1:0] home_cell;
      logic              linked;
   } entity_rec_type;

   localparam int REC_W = $bits(entity_rec_type);

   // Bit masks for writes that touch a single field of an entry.
   localparam entity_rec_type REC_ALL_MASK  = '{link_next: '1, link_prev: '1,
                                                home_cell: '1, linked: 1'b1};
   localparam entity_rec_type REC_NEXT_MASK = '{link_next: '1, link_prev: '0,
                                                home_cell: '0, linked: 1'b0};
   localparam entity_rec_type REC_PREV_MASK = '{link_next: '0, link_prev: '1,
                                                home_cell: '0, linked: 1'b0};

endpackage

`default_nettype wire

>>> rtl/core/spgb_req_if.sv
`default_nettype none

interface spgb_req_if import spgb_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [ID_W-1:0]         entity_id;
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic [POS_W-1:0]        z_pos;

   modport source (output valid, entity_id, x_pos, y_pos, z_pos, input ready);
   modport sink   (input valid, entity_id, x_pos, y_pos, z_pos, output ready);

endinterface

`default_nettype wire

>>> rtl/core/spgb_rsp_if.sv
`default_nettype none

interface spgb_rsp_if import spgb_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STORED_W-1:0] x_stored;
   logic [STORED_W-1:0] y_stored;
   logic [Z_W-1:0]      z_stored;
   logic [CELL_W-1:0]   new_cell;
   logic                cell_changed;
   logic                was_linked;

   modport source (output valid, x_stored, y_stored, z_stored, new_cell,
                   cell_changed, was_linked, input ready);
   modport sink   (input valid, x_stored, y_stored, z_stored, new_cell,
                   cell_changed, was_linked, output ready);

endinterface

`default_nettype wire

>>> rtl/core/spgb_ram.sv
`default_nettype none

module spgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [WIDTH-1:0] wr_mask,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Bit-masked write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wr_mask[i]) begin
               mem_ff[wr_addr][i] <= wr_data[i];
            end
         end
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/spgb_wrap.sv
`default_nettype none

module spgb_wrap import spgb_pkg::*; (
   input  wire logic signed [POS_W-1:0] x_pos,
   input  wire logic signed [POS_W-1:0] y_pos,
   input  wire logic [POS_W-1:0]        z_pos,
   output logic [STORED_W-1:0]          x_stored,
   output logic [STORED_W-1:0]          y_stored,
   output logic [Z_W-1:0]               z_stored,
   output logic [CELL_W-1:0]            new_cell
);

   logic [7:0] x_tile;
   logic [7:0] y_tile;
   logic       x_low;
   logic       x_high;
   logic       y_low;
   logic       y_high;

   // The tile is the high byte, taken as a signed value.
   assign x_tile = x_pos[POS_W-1:POS_W-8];
   assign y_tile = y_pos[POS_W-1:POS_W-8];

   // A tile below one or at the top limit or beyond wraps to a fixed coordinate.
   assign x_low  = x_tile[7] || (x_tile == '0);
   assign x_high = !x_tile[7] && (x_tile >= X_TILE_MAX);
   assign y_low  = y_tile[7] || (y_tile == '0);
   assign y_high = !y_tile[7] && (y_tile >= Y_TILE_MAX);

   always_comb begin
      priority if (x_low) begin
         x_stored = X_LOW_WRAP;
      end else if (x_high) begin
         x_stored = HIGH_WRAP;
      end else begin
         x_stored = x_pos[STORED_W-1:0];
      end

      priority if (y_low) begin
         y_stored = Y_LOW_WRAP;
      end else if (y_high) begin
         y_stored = HIGH_WRAP;
      end else begin
         y_stored = y_pos[STORED_W-1:0];
      end
   end

   assign z_stored = z_pos[Z_W-1:0];

   // The cell index is the y tile over the x tile, seven bits each.
   assign new_cell = {y_stored[STORED_W-1:STORED_W-TILE_W],
                      x_stored[STORED_W-1:STORED_W-TILE_W]};

endmodule

`default_nettype wire

>>> rtl/core/spatial_grid_bucket_relink.sv
`default_nettype none

// Moves one entity per word to a new position on a 128 by 128 tile grid and keeps
// the per-cell doubly linked entity lists up to date. Each req word gives an entity
// and a position; the rsp word gives the wrapped position, its cell and whether the
// entity changed cell and was listed before. The accept cycle reads the cell head
// memory and the entity memory; a decide step then, if the cell changed, writes the
// entity's own entry and the new cell head; further steps patch the neighbor entries
// one at a time (previous neighbor or old cell head, next neighbor, old head of the
// new cell), the old cell head in the head memory and the rest through the single
// write port of the entity memory; a last step loads the output register once it is
// free. A word that keeps its cell skips the patch steps. The next word is accepted
// while a result still waits in the output register. After reset the 16384-entry
// cell head memory is cleared one entry per cycle while req ready is held low.
module spatial_grid_bucket_relink import spgb_pkg::*; #(
   parameter int ENTITY_COUNT = 256
) (
   input wire logic clock,
   input wire logic reset,
   spgb_req_if.sink   req_bus,
   spgb_rsp_if.source rsp_bus
);

   localparam int ENT_DEPTH = (ENTITY_COUNT < ID_SPAN) ? ENTITY_COUNT : ID_SPAN;
   localparam int ENT_AW    = $clog2(ENT_DEPTH);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_UNLINK,
      S_FIX_NEXT,
      S_FIX_HEAD,
      S_OUT
   } state_type;

   // The word under work, after the coordinate wrap.
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic                id_ok;
      logic                rec_valid;
      logic [STORED_W-1:0] x_stored;
      logic [STORED_W-1:0] y_stored;
      logic [Z_W-1:0]      z_stored;
      logic [CELL_W-1:0]   grid_cell;
   } item_type;

   // List repairs still owed for the word under work.
   typedef struct packed {
      logic              changed;
      logic              linked;
      logic              prev_ok;
      logic              next_ok;
      logic              head_ok;
      logic [ID_W-1:0]   prev_id;
      logic [ID_W-1:0]   next_id;
      logic [ID_W-1:0]   head_id;
      logic [CELL_W-1:0] old_cell;
   } plan_type;

   typedef struct packed {
      logic [STORED_W-1:0] x_stored;
      logic [STORED_W-1:0] y_stored;
      logic [Z_W-1:0]      z_stored;
      logic [CELL_W-1:0]   new_cell;
      logic                cell_changed;
      logic                was_linked;
   } rsp_type;

   state_type            state_ff, state_in;
   logic [CELL_W-1:0]    clear_ptr_ff, clear_ptr_in;
   logic [ENT_DEPTH-1:0] ent_valid_ff, ent_valid_in;
   item_type             item_ff, item_in;
   plan_type             plan_ff, plan_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [STORED_W-1:0]  wrap_x;
   logic [STORED_W-1:0]  wrap_y;
   logic [Z_W-1:0]       wrap_z;
   logic [CELL_W-1:0]    wrap_cell;

   logic                 head_wr_en;
   logic [CELL_W-1:0]    head_wr_addr;
   logic [ID_W-1:0]      head_wr_data;
   logic                 head_rd_en;
   logic [ID_W-1:0]      head_rd_data;

   logic                 ent_wr_en;
   logic [ENT_AW-1:0]    ent_wr_addr;
   entity_rec_type       ent_wr_rec;
   entity_rec_type       ent_wr_mask;
   logic                 ent_rd_en;
   logic [REC_W-1:0]     ent_rd_data;

   entity_rec_type       ent_rec;
   logic                 cell_moved;

   function automatic logic id_ok(input logic [ID_W-1:0] e);
      return (e != '0) && (32'(e) < ENTITY_COUNT);
   endfunction

   // Coordinate wrap and cell index of the incoming word.
   spgb_wrap u_wrap (
      .x_pos    (req_bus.x_pos),
      .y_pos    (req_bus.y_pos),
      .z_pos    (req_bus.z_pos),
      .x_stored (wrap_x),
      .y_stored (wrap_y),
      .z_stored (wrap_z),
      .new_cell (wrap_cell)
   );

   // First entity of each cell list.
   spgb_ram #(
      .WIDTH (ID_W),
      .DEPTH (CELL_COUNT)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .wr_mask ({ID_W{1'b1}}),
      .rd_en   (head_rd_en),
      .rd_addr (wrap_cell),
      .rd_data (head_rd_data)
   );

   // Links, cell and list membership of each entity.
   spgb_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENT_DEPTH)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_rec),
      .wr_mask (ent_wr_mask),
      .rd_en   (ent_rd_en),
      .rd_addr (req_bus.entity_id[ENT_AW-1:0]),
      .rd_data (ent_rd_data)
   );

   // An entry never written reads as the cleared record.
   assign ent_rec    = item_ff.rec_valid ? entity_rec_type'(ent_rd_data) : '0;
   assign cell_moved = item_ff.id_ok && (item_ff.grid_cell != ent_rec.home_cell);

   // Next-state logic, memory controls and output register loading.
   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      ent_valid_in = ent_valid_ff;
      item_in      = item_ff;
      plan_in      = plan_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      head_wr_en   = 1'b0;
      head_wr_addr = item_ff.grid_cell;
      head_wr_data = item_ff.id;
      head_rd_en   = 1'b0;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = item_ff.id[ENT_AW-1:0];
      ent_wr_rec   = '0;
      ent_wr_mask  = REC_ALL_MASK;
      ent_rd_en    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the cell head memory to empty lists.
            head_wr_en   = 1'b1;
            head_wr_addr = clear_ptr_ff;
            head_wr_data = '0;
            clear_ptr_in = clear_ptr_ff + 1'b1;
            if (clear_ptr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            // Take a word and read the entity entry and the new cell's head.
            if (req_bus.valid) begin
               head_rd_en        = 1'b1;
               ent_rd_en         = 1'b1;
               item_in.id        = req_bus.entity_id;
               item_in.id_ok     = id_ok(req_bus.entity_id);
               item_in.rec_valid = ent_valid_ff[req_bus.entity_id[ENT_AW-1:0]];
               item_in.x_stored  = wrap_x;
               item_in.y_stored  = wrap_y;
               item_in.z_stored  = wrap_z;
               item_in.grid_cell = wrap_cell;
               state_in          = S_DECIDE;
            end
         end

         S_DECIDE: begin
            plan_in.changed  = cell_moved;
            plan_in.linked   = item_ff.id_ok && ent_rec.linked;
            plan_in.prev_ok  = id_ok(ent_rec.link_prev);
            plan_in.next_ok  = id_ok(ent_rec.link_next);
            plan_in.head_ok  = id_ok(head_rd_data);
            plan_in.prev_id  = ent_rec.link_prev;
            plan_in.next_id  = ent_rec.link_next;
            plan_in.head_id  = head_rd_data;
            plan_in.old_cell = ent_rec.home_cell;
            if (cell_moved) begin
               // Head-insert: the entity's own entry and the new cell's head.
               ent_wr_en                 = 1'b1;
               ent_wr_rec.link_next      = head_rd_data;
               ent_wr_rec.link_prev      = '0;
               ent_wr_rec.home_cell      = item_ff.grid_cell;
               ent_wr_rec.linked         = 1'b1;
               ent_valid_in[ent_wr_addr] = 1'b1;
               head_wr_en                = 1'b1;
            end
            priority if (!cell_moved) begin
               state_in = S_OUT;
            end else if (ent_rec.linked) begin
               state_in = S_UNLINK;
            end else if (id_ok(head_rd_data)) begin
               state_in = S_FIX_HEAD;
            end else begin
               state_in = S_OUT;
            end
         end

         S_UNLINK: begin
            // Bridge the previous neighbor, or the old cell's head, to the next one.
            if (plan_ff.prev_ok) begin
               ent_wr_en            = 1'b1;
               ent_wr_addr          = plan_ff.prev_id[ENT_AW-1:0];
               ent_wr_rec.link_next = plan_ff.next_id;
               ent_wr_mask          = REC_NEXT_MASK;
            end else begin
               head_wr_en   = 1'b1;
               head_wr_addr = plan_ff.old_cell;
               head_wr_data = plan_ff.next_id;
            end
            priority if (plan_ff.next_ok) begin
               state_in = S_FIX_NEXT;
            end else if (plan_ff.head_ok) begin
               state_in = S_FIX_HEAD;
            end else begin
               state_in = S_OUT;
            end
         end

         S_FIX_NEXT: begin
            // The next neighbor now points back past the entity.
            ent_wr_en            = 1'b1;
            ent_wr_addr          = plan_ff.next_id[ENT_AW-1:0];
            ent_wr_rec.link_prev = plan_ff.prev_id;
            ent_wr_mask          = REC_PREV_MASK;
            state_in             = plan_ff.head_ok ? S_FIX_HEAD : S_OUT;
         end

         S_FIX_HEAD: begin
            // The former head of the new cell points back to the entity.
            ent_wr_en            = 1'b1;
            ent_wr_addr          = plan_ff.head_id[ENT_AW-1:0];
            ent_wr_rec.link_prev = item_ff.id;
            ent_wr_mask          = REC_PREV_MASK;
            state_in             = S_OUT;
         end

         S_OUT: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.x_stored     = item_ff.x_stored;
               rsp_in.y_stored     = item_ff.y_stored;
               rsp_in.z_stored     = item_ff.z_stored;
               rsp_in.new_cell     = item_ff.grid_cell;
               rsp_in.cell_changed = plan_ff.changed;
               rsp_in.was_linked   = plan_ff.linked;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, valid bits and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ptr_ff <= '0;
         ent_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         ent_valid_ff <= ent_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      plan_ff <= plan_in;
      rsp_ff  <= rsp_in;
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.x_stored     = rsp_ff.x_stored;
   assign rsp_bus.y_stored     = rsp_ff.y_stored;
   assign rsp_bus.z_stored     = rsp_ff.z_stored;
   assign rsp_bus.new_cell     = rsp_ff.new_cell;
   assign rsp_bus.cell_changed = rsp_ff.cell_changed;
   assign rsp_bus.was_linked   = rsp_ff.was_linked;

`ifndef SYNTHESIS
   // The decide step always works on a word taken in the cycle before.
   a_decide_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> $past(req_bus.valid && req_bus.ready))
      else $error("decide step without an accepted word");

   // Neighbor repairs never write the moving entity's own entry.
   a_neighbor_not_self: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UNLINK) || (state_ff == S_FIX_NEXT) || (state_ff == S_FIX_HEAD))
      && ent_wr_en |-> (ent_wr_addr != item_ff.id[ENT_AW-1:0]))
      else $error("neighbor repair targets the moving entity");

   // While the head memory is swept, no word is taken and no entity is written.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!req_bus.ready && !ent_wr_en))
      else $error("activity during the head memory sweep");

   // A wrapped position never lands in cell zero.
   a_cell_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.new_cell != '0))
      else $error("result word in cell zero");
`endif

endmodule

`default_nettype wire

>>> tb/sv/spatial_grid_bucket_relink_tb.sv
`default_nettype none

module spatial_grid_bucket_relink_tb;
   import spgb_pkg::*;

   localparam int ENTITY_COUNT  = 256;
   localparam int MOVE_TOTAL    = 1450;
   localparam int QUIET_TAIL    = 200;
   localparam int DRAIN_AT      = 900;
   localparam int HOLD_OFF_AT   = 300;
   localparam int LONG_HOLD_OFF = 400;
   localparam int IDLE_LIMIT    = 50000;
   localparam int DRAIN_CYCLES  = 20;

   // One request word: an entity and the position it moves to.
   typedef struct packed {
      logic [ID_W-1:0]         entity_id;
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
      logic [POS_W-1:0]        z_pos;
   } move_word_type;

   // One response word: where the entity ended up.
   typedef struct packed {
      logic [STORED_W-1:0] x_stored;
      logic [STORED_W-1:0] y_stored;
      logic [Z_W-1:0]      z_stored;
      logic [CELL_W-1:0]   new_cell;
      logic                cell_changed;
      logic                was_linked;
   } placement_type;

   logic clock;
   logic reset;

   spgb_req_if req_bus ();
   spgb_rsp_if rsp_bus ();

   spatial_grid_bucket_relink #(
      .ENTITY_COUNT(ENTITY_COUNT)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Shadow copy of the grid lists; bit arrays start at zero like the cleared block.
   bit [ID_W-1:0]   shadow_head [CELL_COUNT];
   bit [ID_W-1:0]   shadow_next [ENTITY_COUNT];
   bit [ID_W-1:0]   shadow_prev [ENTITY_COUNT];
   bit [CELL_W-1:0] shadow_cell [ENTITY_COUNT];
   bit              shadow_listed [ENTITY_COUNT];

   move_word_type pending_moves [$];
   placement_type expected_placements [$];

   int  mismatch_count = 0;
   int  placements_seen = 0;
   int  moves_issued = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_off_left = 0;
   bit  hold_off_done = 1'b0;
   bit  drain_pending = 1'b0;
   logic req_fire = 1'b0;

   function automatic bit entity_valid(input logic [ID_W-1:0] id);
      return (id != '0) && (int'(id) < ENTITY_COUNT);
   endfunction

   // Applies one move to the shadow lists and returns the placement it must produce.
   function automatic placement_type relocate_entity(input move_word_type mv);
      placement_type      pl;
      logic signed [7:0]  x_tile;
      logic signed [7:0]  y_tile;
      logic [POS_W-1:0]   xw;
      logic [POS_W-1:0]   yw;
      logic [CELL_W-1:0]  new_cell_idx;
      logic [CELL_W-1:0]  old_cell;
      logic [ID_W-1:0]    id;
      logic [ID_W-1:0]    prv;
      logic [ID_W-1:0]    nxt;
      logic [ID_W-1:0]    head;

      id     = mv.entity_id;
      x_tile = mv.x_pos[15:8];
      y_tile = mv.y_pos[15:8];

      // Out-of-range tiles wrap to fixed coordinates.
      if (x_tile < 8'sd1) begin
         xw = POS_W'(X_LOW_WRAP);
      end else if (x_tile >= $signed(X_TILE_MAX)) begin
         xw = POS_W'(HIGH_WRAP);
      end else begin
         xw = mv.x_pos;
      end
      if (y_tile < 8'sd1) begin
         yw = POS_W'(Y_LOW_WRAP);
      end else if (y_tile >= $signed(Y_TILE_MAX)) begin
         yw = POS_W'(HIGH_WRAP);
      end else begin
         yw = mv.y_pos;
      end
      new_cell_idx = {yw[14:8], xw[14:8]};

      pl.x_stored     = xw[STORED_W-1:0];
      pl.y_stored     = yw[STORED_W-1:0];
      pl.z_stored     = mv.z_pos[Z_W-1:0];
      pl.new_cell     = new_cell_idx;
      pl.cell_changed = 1'b0;
      pl.was_linked   = 1'b0;

      // A null entity leaves the lists alone.
      if (entity_valid(id)) begin
         old_cell      = shadow_cell[id];
         pl.was_linked = shadow_listed[id];
         if (new_cell_idx != old_cell) begin
            pl.cell_changed = 1'b1;
            // Take the entity out of its old list first.
            if (shadow_listed[id]) begin
               prv = shadow_prev[id];
               nxt = shadow_next[id];
               if (entity_valid(prv)) begin
                  shadow_next[prv] = nxt;
               end else begin
                  shadow_head[old_cell] = nxt;
               end
               if (entity_valid(nxt)) begin
                  shadow_prev[nxt] = prv;
               end
               shadow_listed[id] = 1'b0;
            end
            // Then put it at the head of the new cell's list.
            head            = shadow_head[new_cell_idx];
            shadow_prev[id] = '0;
            shadow_next[id] = head;
            if (entity_valid(head)) begin
               shadow_prev[head] = id;
            end
            shadow_head[new_cell_idx] = id;
            shadow_listed[id]         = 1'b1;
         end
         shadow_cell[id] = new_cell_idx;
      end
      return pl;
   endfunction

   task automatic add_move(input logic [ID_W-1:0] id, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
      move_word_type mv;
      mv.entity_id = id;
      mv.x_pos     = x;
      mv.y_pos     = y;
      mv.z_pos     = z;
      pending_moves.push_back(mv);
   endtask

   // Mostly a few entities shuffling among a handful of cells, so lists grow long.
   task automatic add_random_move();
      int               pick;
      logic [7:0]       x_tile;
      logic [7:0]       y_tile;
      logic [ID_W-1:0]  id;

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         add_move('0, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      end else if (pick < 78) begin
         id     = ID_W'($urandom_range(1, 16));
         x_tile = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(1, 3))
                                              : 8'($urandom_range(0, 255));
         y_tile = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(1, 2))
                                              : 8'($urandom_range(0, 255));
         add_move(id, {x_tile, 8'($urandom)}, {y_tile, 8'($urandom)}, POS_W'($urandom));
      end else begin
         add_move(ID_W'($urandom_range(1, 255)), POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom));
      end
   endtask

   task automatic compare_field(input string field_name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, field_name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Free-running clock.
   initial clock = 1'b0;
   always begin
      #5 clock = ~clock;
   end

   // Sender: offers the next queued word once the current one has been taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (drain_pending && expected_placements.size() != 0) begin
               req_bus.valid <= 1'b0;
            end else if (pending_moves.size() != 0) begin
               move_word_type mv;
               drain_pending = 1'b0;
               mv = pending_moves.pop_front();
               req_bus.entity_id <= mv.entity_id;
               req_bus.x_pos     <= mv.x_pos;
               req_bus.y_pos     <= mv.y_pos;
               req_bus.z_pos     <= mv.z_pos;
               req_bus.valid     <= 1'b1;
               moves_issued++;
               if (moves_issued == DRAIN_AT) begin
                  drain_pending = 1'b1;
               end
               if (moves_issued < MOVE_TOTAL - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(1, 4);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random short stalls, one long hold-off, none near the end.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_off_done && placements_seen >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         hold_off_left = LONG_HOLD_OFF - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (placements_seen < MOVE_TOTAL - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: predicts each accepted request word and checks each response word.
   always @(posedge clock) begin
      placement_type act;
      placement_type exp_pl;
      logic          req_taken;
      logic          rsp_taken;

      req_taken = !reset && req_bus.valid && req_bus.ready;
      rsp_taken = !reset && rsp_bus.valid && rsp_bus.ready;
      req_fire <= req_taken;

      if (req_taken) begin
         expected_placements.push_back(relocate_entity({req_bus.entity_id, req_bus.x_pos,
                                                        req_bus.y_pos, req_bus.z_pos}));
      end

      if (rsp_taken) begin
         act = {rsp_bus.x_stored, rsp_bus.y_stored, rsp_bus.z_stored, rsp_bus.new_cell,
                rsp_bus.cell_changed, rsp_bus.was_linked};
         if (expected_placements.size() == 0) begin
            $display("%0t: unexpected response word: expected none, actual 0x%0h",
                     $time, act);
            mismatch_count++;
         end else begin
            exp_pl = expected_placements.pop_front();
            compare_field("x_stored", 16'(exp_pl.x_stored), 16'(act.x_stored));
            compare_field("y_stored", 16'(exp_pl.y_stored), 16'(act.y_stored));
            compare_field("z_stored", 16'(exp_pl.z_stored), 16'(act.z_stored));
            compare_field("new_cell", 16'(exp_pl.new_cell), 16'(act.new_cell));
            compare_field("cell_changed", 16'(exp_pl.cell_changed), 16'(act.cell_changed));
            compare_field("was_linked", 16'(exp_pl.was_linked), 16'(act.was_linked));
         end
         placements_seen++;
      end

      // Watchdog on cycles where neither side moves a word.
      if (req_taken || rsp_taken) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.entity_id = '0;
      req_bus.x_pos     = '0;
      req_bus.y_pos     = '0;
      req_bus.z_pos     = '0;
      rsp_bus.ready     = 1'b0;

      // Directed part: list surgery at head, middle and tail, wraps and null entity.
      add_move(8'd1, 16'h0100, 16'h0100, 16'h0000);   // first move, lowest tiles
      add_move(8'd2, 16'h01ff, 16'h01ff, 16'h0fff);   // joins a non-empty cell
      add_move(8'd3, 16'h0180, 16'h0140, 16'hf000);   // list is now 3, 2, 1
      add_move(8'd2, 16'h0111, 16'h0122, 16'h1234);   // same cell, lists untouched
      add_move(8'd2, 16'h0200, 16'h0100, 16'h0abc);   // leaves from the middle
      add_move(8'd3, 16'h0300, 16'h0100, 16'h0001);   // leaves from the head
      add_move(8'd1, 16'h0300, 16'h0100, 16'h0002);   // lone entry leaves its cell
      add_move(8'd3, 16'h0200, 16'h0100, 16'h0003);   // leaves from the tail
      add_move(8'd0, 16'h8000, 16'h7fff, 16'hffff);   // null entity, both tiles wrap
      add_move(8'd0, 16'h0000, 16'h0000, 16'h0000);
      add_move(8'd255, 16'h7eff, 16'h5eff, 16'h0000); // largest tiles that do not wrap
      add_move(8'd255, 16'h7f00, 16'h5f00, 16'h1000); // first tiles that wrap high
      add_move(8'd255, 16'h00ff, 16'hffff, 16'hffff); // tile zero and tile minus one
      add_move(8'd254, 16'h7fff, 16'h8000, 16'h5555);
      add_move(8'd254, 16'hffff, 16'h7fff, 16'haaaa);
      add_move(8'd128, 16'h5a5a, 16'h2a2a, 16'h0fff);
      add_move(8'd128, 16'h5aa5, 16'h2a55, 16'h0001); // same cell again
      add_move(8'd4, 16'h0200, 16'h0100, 16'h0000);   // third entry in a shared cell

      while (pending_moves.size() < MOVE_TOTAL) begin
         add_random_move();
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every word to go out and every placement to come back.
      while (pending_moves.size() != 0 || req_bus.valid || expected_placements.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/core/spgb_pkg.sv
rtl/core/spgb_req_if.sv
rtl/core/spgb_rsp_if.sv
rtl/core/spgb_ram.sv
rtl/core/spgb_wrap.sv
rtl/core/spatial_grid_bucket_relink.sv
tb/sv/spatial_grid_bucket_relink_tb.sv
